@@ src/rcrt_pkg.sv @@
// Shared constants, types and a helper function of the rectangle claim table.
package rcrt_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int COORD_WIDTH = 32;
    localparam int ID_W        = 64;
    localparam int IN_COORD_W  = 32;
    localparam int LIMIT_W     = 7;
    localparam int HELD_W      = 7;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    // Request kinds.
    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_RELEASE  = 1'b1;

    // Result codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_CONFLICT = 2'd2,
        STATUS_NOTFOUND = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // One table entry; coordinates are kept as offset-binary keys.
    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [COORD_WIDTH-1:0] min_x;
        logic [COORD_WIDTH-1:0] min_y;
        logic [COORD_WIDTH-1:0] max_x;
        logic [COORD_WIDTH-1:0] max_y;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Compare results for one stored entry against the current request.
    typedef struct packed {
        logic overlap;
        logic id_eq;
    } match_t;

    // Sign-extend, wrap to the coordinate width and flip the sign bit, so that
    // an unsigned compare of two keys orders them as signed values.
    function automatic logic [COORD_WIDTH-1:0] coord_key(input logic [IN_COORD_W-1:0] raw);
        logic [2*ID_W-1:0] ext;
        ext = {{(2*ID_W-IN_COORD_W){raw[IN_COORD_W-1]}}, raw};
        return ext[COORD_WIDTH-1:0] ^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
    endfunction

endpackage

@@ src/rcrt_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module rcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/rcrt_match.sv @@
// Strict rectangle overlap test and id compare of one stored entry.
module rcrt_match (
    input  rcrt_pkg::entry_t stored,
    input  rcrt_pkg::entry_t req,
    output rcrt_pkg::match_t result
);
    import rcrt_pkg::*;

    logic x_apart;
    logic y_apart;

    // Touching edges do not count as overlap: max bounds are exclusive.
    always_comb
    begin
        x_apart        = (stored.max_x <= req.min_x) || (req.max_x <= stored.min_x);
        y_apart        = (stored.max_y <= req.min_y) || (req.max_y <= stored.min_y);
        result.overlap = !x_apart && !y_apart;
        result.id_eq   = (stored.id == req.id);
    end

endmodule

@@ src/rect_claim_reservation_table_unit.sv @@
// Top level of the rectangle claim reservation table: sequencer, table RAM, config.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | mode, req_id, min_x, min_y, max_x, max_y
//  output   | out_valid / out_stall| status, conflict_id, entries_held
//  config   | cfg_valid / cfg_ready| table_limit
//
// One request is handled at a time; the scan and the shift each move one entry
// per cycle through the table RAM port. A register request on a full table skips
// the scan and goes straight to the result.
// Reset clears the claim count and sets the limit to 64; the RAM is not cleared.
// A stalled result is held in the output register while the next request runs.
module rect_claim_reservation_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [rcrt_pkg::ID_W-1:0]       req_id,
    input  logic signed [rcrt_pkg::IN_COORD_W-1:0] min_x,
    input  logic signed [rcrt_pkg::IN_COORD_W-1:0] min_y,
    input  logic signed [rcrt_pkg::IN_COORD_W-1:0] max_x,
    input  logic signed [rcrt_pkg::IN_COORD_W-1:0] max_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [rcrt_pkg::ID_W-1:0]       conflict_id,
    output logic [rcrt_pkg::HELD_W-1:0]     entries_held,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcrt_pkg::LIMIT_W-1:0]    table_limit
);
    import rcrt_pkg::*;

    state_t             state_reg, state_next;
    logic               mode_reg, mode_next;
    entry_t             req_reg, req_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    status_t            res_status_reg, res_status_next;
    logic [ID_W-1:0]    res_conflict_reg, res_conflict_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [ID_W-1:0]    out_conflict_reg, out_conflict_next;
    logic [HELD_W-1:0]  out_held_reg, out_held_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_rdata;
    match_t             match;
    logic [CMP_W-1:0]   eff_limit;
    logic               hit;

    // Table storage.
    rcrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Compare of the entry just read against the request.
    rcrt_match u_match (
        .stored (mem_rdata),
        .req    (req_reg),
        .result (match)
    );

    // Limit register; the user must write it only while the table is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= table_limit;
        end
    end

    // A limit above the table depth acts as the depth.
    assign eff_limit = (CMP_W'(limit_reg) > CMP_W'(TABLE_DEPTH)) ?
                       CMP_W'(TABLE_DEPTH) : CMP_W'(limit_reg);

    assign hit = (mode_reg == MODE_REGISTER) ? match.overlap : match.id_eq;

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and index registers.
    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        req_reg          <= req_next;
        issue_idx_reg    <= issue_idx_next;
        chk_idx_reg      <= chk_idx_next;
        wr_idx_reg       <= wr_idx_next;
        res_status_reg   <= res_status_next;
        res_conflict_reg <= res_conflict_next;
        out_status_reg   <= out_status_next;
        out_conflict_reg <= out_conflict_next;
        out_held_reg     <= out_held_next;
    end

    // Sequencer: scan with one read in flight, then shift, append or just report the result.
    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        req_next          = req_reg;
        count_next        = count_reg;
        issue_idx_next    = issue_idx_reg;
        chk_valid_next    = chk_valid_reg;
        chk_idx_next      = chk_idx_reg;
        wr_idx_next       = wr_idx_reg;
        res_status_next   = res_status_reg;
        res_conflict_next = res_conflict_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_status_next   = out_status_reg;
        out_conflict_next = out_conflict_reg;
        out_held_next     = out_held_reg;
        in_stall          = (state_reg != ST_IDLE);
        mem_we            = 1'b0;
        mem_waddr         = count_reg[IDX_W-1:0];
        mem_wdata         = req_reg;
        mem_re            = 1'b0;
        mem_raddr         = issue_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next         = mode;
                    req_next.id       = req_id;
                    req_next.min_x    = coord_key(min_x);
                    req_next.min_y    = coord_key(min_y);
                    req_next.max_x    = coord_key(max_x);
                    req_next.max_y    = coord_key(max_y);
                    issue_idx_next    = '0;
                    chk_valid_next    = 1'b0;
                    res_conflict_next = '0;
                    res_status_next   = STATUS_OK;
                    if ((mode == MODE_REGISTER) && (CMP_W'(count_reg) >= eff_limit))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (chk_valid_reg && hit)
                begin
                    if (mode_reg == MODE_REGISTER)
                    begin
                        res_status_next   = STATUS_CONFLICT;
                        res_conflict_next = mem_rdata.id;
                        chk_valid_next    = 1'b0;
                        state_next        = ST_DONE;
                    end
                    else
                    begin
                        // Close the gap from the matching entry upward.
                        wr_idx_next    = chk_idx_reg;
                        issue_idx_next = CNT_W'(chk_idx_reg) + CNT_W'(1);
                        chk_valid_next = 1'b0;
                        state_next     = ST_SHIFT;
                    end
                end
                else if (issue_idx_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    chk_idx_next   = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    // Every held entry was checked without a hit.
                    chk_valid_next = 1'b0;
                    if (mode_reg == MODE_REGISTER)
                    begin
                        mem_we          = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = STATUS_OK;
                    end
                    else
                    begin
                        res_status_next = STATUS_NOTFOUND;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT:
            begin
                if (chk_valid_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_idx_reg;
                    mem_wdata   = mem_rdata;
                    wr_idx_next = wr_idx_reg + IDX_W'(1);
                end
                if (issue_idx_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        count_next      = count_reg - CNT_W'(1);
                        res_status_next = STATUS_OK;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = res_status_reg;
                    out_conflict_next = res_conflict_reg;
                    out_held_next     = HELD_W'(count_reg);
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output port drive.
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign conflict_id  = out_conflict_reg;
    assign entries_held = out_held_reg;

endmodule

@@ src/rcrt_checker.sv @@
// Port-level assertions for the rectangle claim reservation table, with its bind.
module rcrt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [1:0]                status,
    input logic [rcrt_pkg::ID_W-1:0] conflict_id
);
    import rcrt_pkg::*;

    // A conflict id is reported only with a conflict status.
    a_conflict_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_CONFLICT)) |-> (conflict_id == '0))
        else $error("conflict_id nonzero without a conflict status");

    // One request at a time: an accepted transaction blocks the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after a transaction");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(status) && $stable(conflict_id)))
        else $error("stalled result changed");

endmodule

bind rect_claim_reservation_table_unit rcrt_checker u_rcrt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .conflict_id (conflict_id)
);
